### src/assert_macros.svh
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every edge out of reset
`define ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// ante implies cons in the same cycle
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### src/fpsqn_pkg.sv
package fpsqn_pkg;

    localparam logic [63:0] QNAN_BITS = 64'h7FF8_0000_0000_0000;
    localparam logic [63:0] PINF_BITS = 64'h7FF0_0000_0000_0000;

    typedef enum logic [1:0] {
        OP_DIV,
        OP_ADD,
        OP_HALF
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

endpackage

### src/fpsqn_alu.sv
module fpsqn_alu
    import fpsqn_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  alu_req_t    req,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        busy,
    output logic        done,
    output logic [63:0] res
);

    typedef enum logic [1:0] {
        A_IDLE,
        A_NORM,
        A_DIV,
        A_RND
    } astate_t;

    astate_t            state_reg, state_next;
    logic [52:0]        ma_reg, ma_next, mb_reg, mb_next;
    logic signed [13:0] ea_reg, ea_next, eb_reg, eb_next;
    logic [53:0]        rem_reg, rem_next;
    logic [56:0]        quo_reg, quo_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic [56:0]        rm_reg, rm_next;
    logic signed [13:0] rexp_reg, rexp_next;
    logic               rst_reg, rst_next;
    logic [63:0]        res_reg, res_next;
    logic               done_reg, done_next;

    // round-to-nearest-even pack; m has its leading one at bit 56 or 55
    function automatic logic [63:0] round_pack(input logic [56:0] m,
                                               input logic signed [13:0] e,
                                               input logic st);
        logic [56:0]        mn;
        logic [56:0]        ms;
        logic signed [13:0] bexp;
        logic [5:0]         sh;
        logic [10:0]        expf;
        logic               lost;
        logic               up;
        mn   = m[56] ? m : {m[55:0], 1'b0};
        bexp = m[56] ? (e + 14'sd1079) : (e + 14'sd1078);
        if (bexp >= 14'sd2047) begin
            return PINF_BITS;
        end
        if (bexp < 14'sd1) begin
            sh   = ((14'sd1 - bexp) > 14'sd63) ? 6'd63 : 6'((14'sd1 - bexp));
            expf = 11'd0;
        end
        else begin
            sh   = 6'd0;
            expf = bexp[10:0];
        end
        ms   = mn >> sh;
        lost = ((ms << sh) != mn);
        up   = ms[3] & ((|ms[2:0]) | lost | st | ms[4]);
        return {1'b0, expf, ms[55:4]} + {63'd0, up};
    endfunction

    function automatic logic [63:0] halve(input logic [63:0] v);
        logic [52:0] m;
        m = {v[52], v[51:0]};
        if (v[62:52] >= 11'd2) begin
            return v - 64'h0010_0000_0000_0000;
        end
        return {12'd0, m[52:1]} + {63'd0, m[0] & m[1]};
    endfunction

    logic [10:0]        efa, efb;
    logic [52:0]        mua, mub;
    logic signed [13:0] lsa, lsb;
    logic               a_big;
    logic [52:0]        mbig, msml;
    logic signed [13:0] lbig, lsml;
    logic [13:0]        dalign;
    logic [5:0]         dsh;
    logic [55:0]        sml_al, sml_sh;
    logic               sml_lost;
    logic [56:0]        sum;
    logic               qbit;
    logic [53:0]        rdiff;

    always_comb
    begin
        efa      = a[62:52];
        efb      = b[62:52];
        mua      = {efa != 11'd0, a[51:0]};
        mub      = {efb != 11'd0, b[51:0]};
        lsa      = $signed({3'd0, (efa == 11'd0) ? 11'd1 : efa}) - 14'sd1075;
        lsb      = $signed({3'd0, (efb == 11'd0) ? 11'd1 : efb}) - 14'sd1075;
        a_big    = (efa >= efb);
        mbig     = a_big ? mua : mub;
        msml     = a_big ? mub : mua;
        lbig     = a_big ? lsa : lsb;
        lsml     = a_big ? lsb : lsa;
        dalign   = 14'(lbig - lsml);
        dsh      = (dalign > 14'd63) ? 6'd63 : dalign[5:0];
        sml_al   = {msml, 3'b000};
        sml_sh   = sml_al >> dsh;
        sml_lost = ((sml_sh << dsh) != sml_al);
        sum      = {1'b0, mbig, 3'b000} + {1'b0, sml_sh};
        qbit     = ({1'b0, rem_reg} >= {1'b0, mb_reg});
        rdiff    = qbit ? (rem_reg - {1'b0, mb_reg}) : rem_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        ma_next    = ma_reg;
        mb_next    = mb_reg;
        ea_next    = ea_reg;
        eb_next    = eb_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        rm_next    = rm_reg;
        rexp_next  = rexp_reg;
        rst_next   = rst_reg;
        res_next   = res_reg;
        done_next  = 1'b0;
        case (state_reg)
            A_IDLE:
            begin
                if (req.start) begin
                    case (req.op)
                        OP_HALF:
                        begin
                            res_next  = halve(a);
                            done_next = 1'b1;
                        end
                        OP_ADD:
                        begin
                            if (efa == 11'd0 && efb == 11'd0) begin
                                res_next  = a + b;
                                done_next = 1'b1;
                            end
                            else begin
                                rm_next    = sum;
                                rexp_next  = lbig - 14'sd3;
                                rst_next   = sml_lost;
                                state_next = A_RND;
                            end
                        end
                        OP_DIV:
                        begin
                            ma_next    = mua;
                            mb_next    = mub;
                            ea_next    = lsa;
                            eb_next    = lsb;
                            state_next = A_NORM;
                        end
                        default:
                        begin
                            res_next  = a;
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            A_NORM:
            begin
                if (!ma_reg[52]) begin
                    ma_next = {ma_reg[51:0], 1'b0};
                    ea_next = ea_reg - 14'sd1;
                end
                if (!mb_reg[52]) begin
                    mb_next = {mb_reg[51:0], 1'b0};
                    eb_next = eb_reg - 14'sd1;
                end
                if (ma_reg[52] && mb_reg[52]) begin
                    rem_next   = {1'b0, ma_reg};
                    quo_next   = '0;
                    cnt_next   = '0;
                    state_next = A_DIV;
                end
            end
            A_DIV:
            begin
                quo_next = {quo_reg[55:0], qbit};
                rem_next = {rdiff[52:0], 1'b0};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd56) begin
                    rm_next    = {quo_reg[55:0], qbit};
                    rexp_next  = ea_reg - eb_reg - 14'sd56;
                    rst_next   = (rdiff != 54'd0);
                    state_next = A_RND;
                end
            end
            A_RND:
            begin
                res_next   = round_pack(rm_reg, rexp_reg, rst_reg);
                done_next  = 1'b1;
                state_next = A_IDLE;
            end
            default:
            begin
                state_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else begin
            state_reg <= state_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ma_reg   <= ma_next;
        mb_reg   <= mb_next;
        ea_reg   <= ea_next;
        eb_reg   <= eb_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        rm_reg   <= rm_next;
        rexp_reg <= rexp_next;
        rst_reg  <= rst_next;
        res_reg  <= res_next;
    end

    assign busy = (state_reg != A_IDLE);
    assign done = done_reg;
    assign res  = res_reg;

endmodule

### src/fp_double_sqrt_newton_core.sv
// Square root of one IEEE 754 double by bounded Newton-Raphson iteration.
// Input channel s_axis_*: one 64-bit operand pattern per transfer.
// Output channel m_axis_*: one 64-bit root pattern per input, in order.
// s_axis_tready is high only while the sequencer is idle; one operand is
// worked at a time. Negative, zero, NaN and infinity operands bypass the
// iteration. Other operands run up to MAX_ITERATIONS steps of
// guess = (guess + x/guess) * 0.5 on one shared arithmetic unit, stopping
// early when the guess no longer changes. A step is operand
// normalization, a bit-serial divide, then add, halve and rounding.
// A finished result is held in the output register until taken; while
// m_axis_tready is low the next operand may be accepted but its result
// waits in the sequencer. Reset clears all control state and drops
// m_axis_tvalid.
module fp_double_sqrt_newton_core
    import fpsqn_pkg::*;
#(
    parameter int MAX_ITERATIONS = 30
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [63:0] operand_bits
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata    // [63:0] root_bits
);

    localparam int ItW = (MAX_ITERATIONS > 1) ? $clog2(MAX_ITERATIONS) : 1;

    typedef enum logic [2:0] {
        T_IDLE,
        T_DIV,
        T_ADD,
        T_HALF,
        T_DONE
    } tstate_t;

    tstate_t     state_reg;
    logic [63:0] x_reg, guess_reg, a_reg, b_reg, result_reg, out_reg;
    logic [ItW-1:0] iter_reg;
    alu_req_t    req_reg;
    logic        out_valid_reg;
    logic        alu_busy, alu_done;
    logic [63:0] alu_res;
    logic        in_nan, in_zero, in_pinf, take;
    logic        alu_wait;

    fpsqn_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_reg),
        .a     (a_reg),
        .b     (b_reg),
        .busy  (alu_busy),
        .done  (alu_done),
        .res   (alu_res)
    );

    assign in_nan  = (s_axis_tdata[62:52] == 11'h7FF) && (s_axis_tdata[51:0] != 52'd0);
    assign in_zero = (s_axis_tdata[62:0] == 63'd0);
    assign in_pinf = (s_axis_tdata == PINF_BITS);
    assign take    = s_axis_tvalid && (state_reg == T_IDLE);
    assign alu_wait = state_reg inside {T_DIV, T_ADD, T_HALF};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= T_IDLE;
            req_reg       <= '{start: 1'b0, op: OP_DIV};
            out_valid_reg <= 1'b0;
            iter_reg      <= '0;
        end
        else begin
            if (state_reg == T_DONE) begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                T_IDLE:
                begin
                    if (take) begin
                        if (in_nan || in_zero || in_pinf) begin
                            result_reg <= s_axis_tdata;
                            state_reg  <= T_DONE;
                        end
                        else if (s_axis_tdata[63]) begin
                            result_reg <= QNAN_BITS;
                            state_reg  <= T_DONE;
                        end
                        else begin
                            x_reg     <= s_axis_tdata;
                            guess_reg <= s_axis_tdata;
                            a_reg     <= s_axis_tdata;
                            b_reg     <= s_axis_tdata;
                            iter_reg  <= '0;
                            req_reg   <= '{start: 1'b1, op: OP_DIV};
                            state_reg <= T_DIV;
                        end
                    end
                end
                T_DIV:
                begin
                    if (alu_done) begin
                        a_reg     <= guess_reg;
                        b_reg     <= alu_res;
                        req_reg   <= '{start: 1'b1, op: OP_ADD};
                        state_reg <= T_ADD;
                    end
                    else begin
                        req_reg.start <= 1'b0;
                    end
                end
                T_ADD:
                begin
                    if (alu_done) begin
                        a_reg     <= alu_res;
                        req_reg   <= '{start: 1'b1, op: OP_HALF};
                        state_reg <= T_HALF;
                    end
                    else begin
                        req_reg.start <= 1'b0;
                    end
                end
                T_HALF:
                begin
                    if (alu_done) begin
                        if (alu_res == guess_reg
                            || iter_reg == ItW'(MAX_ITERATIONS - 1)) begin
                            result_reg <= alu_res;
                            state_reg  <= T_DONE;
                        end
                        else begin
                            guess_reg <= alu_res;
                            a_reg     <= x_reg;
                            b_reg     <= alu_res;
                            iter_reg  <= iter_reg + 1'b1;
                            req_reg   <= '{start: 1'b1, op: OP_DIV};
                            state_reg <= T_DIV;
                        end
                    end
                    else begin
                        req_reg.start <= 1'b0;
                    end
                end
                T_DONE:
                begin
                    if (!out_valid_reg || m_axis_tready) begin
                        out_reg   <= result_reg;
                        state_reg <= T_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == T_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;

    `include "assert_macros.svh"

    `ASSERT_IMPLIES(a_idle_alu_free, !alu_wait, !alu_busy, "alu busy while sequencer idle")
    `ASSERT_IMPLIES(a_done_expected, alu_done, alu_wait, "unexpected alu completion")
    `ASSERT_ALWAYS(a_iter_bound, 32'(iter_reg) < MAX_ITERATIONS, "iteration count past limit")

endmodule

### tb/fpsqn_checker.sv
`timescale 1ns / 100ps

module fpsqn_checker
    import fpsqn_pkg::*;
#(
    parameter int MAX_ITERATIONS = 30
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [63:0] m_axis_tdata,
    output int          errors,
    output int          pending,
    output int          results_seen
);

    logic [63:0] root_q[$];

    function automatic logic [63:0] newton_root(input logic [63:0] xb);
        real x;
        real guess;
        real nxt;
        logic is_nan;
        x      = $bitstoreal(xb);
        is_nan = (xb[62:52] == 11'h7FF) && (xb[51:0] != 52'd0);
        if (is_nan)
            return xb;
        if (xb[62:0] == 63'd0)
            return xb;
        if (xb[63])
            return QNAN_BITS;
        if (xb == PINF_BITS)
            return PINF_BITS;
        guess = x;
        for (int i = 0; i < MAX_ITERATIONS; i++)
        begin
            nxt = (guess + x / guess) * 0.5;
            if (nxt == guess)
                break;
            guess = nxt;
        end
        return $realtobits(guess);
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp_v);
        errors++;
        $display("[%0t] mismatch: %s got %h expected %h", $realtime, what, got, exp_v);
    endtask

    initial
    begin
        errors       = 0;
        results_seen = 0;
    end

    assign pending = root_q.size();

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                root_q.push_back(newton_root(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                if (root_q.size() == 0)
                    report("unexpected root_bits", m_axis_tdata, 64'd0);
                else if (m_axis_tdata !== root_q[0])
                begin
                    report("root_bits", m_axis_tdata, root_q[0]);
                    void'(root_q.pop_front());
                end
                else
                    void'(root_q.pop_front());
            end
        end
    end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import fpsqn_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;

    int errors;
    int pending;
    int results_seen;
    int items_sent;
    int idle_cnt;
    bit idle_on;
    bit long_hold;

    fp_double_sqrt_newton_core #(.MAX_ITERATIONS(30)) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    fpsqn_checker #(.MAX_ITERATIONS(30)) i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .errors        (errors),
        .pending       (pending),
        .results_seen  (results_seen)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cnt <= 0;
        else
        begin
            idle_cnt <= idle_cnt + 1;
            if (idle_cnt >= WATCHDOG_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // receiver
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge clk);
                long_hold = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send_operand(input logic [63:0] x);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= x;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    function automatic logic [63:0] random_operand();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v[62:52] = 11'($urandom_range(1013, 1033));
            4:          v[62:52] = 11'h7FF;
            5:          v[62:52] = 11'h000;
            6, 7:       v[63]    = 1'b1;
            default:    ;
        endcase
        if (v[62:52] != 11'h7FF && v[62:52] > 11'd1100 && !v[63] && $urandom_range(0, 1))
            v[62:52] = 11'($urandom_range(900, 1100));
        return v;
    endfunction

    initial
    begin
        logic [63:0] directed_ops[$];
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 64'd0;
        items_sent    = 0;
        idle_cnt      = 0;
        idle_on       = 1'b1;
        long_hold     = 1'b0;
        directed_ops = '{
            64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000,
            PINF_BITS,               64'hFFF0_0000_0000_0000,
            QNAN_BITS,               64'h7FF0_0000_0000_0001,
            64'hFFFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF,
            64'h0000_0000_0000_0001, 64'h000F_FFFF_FFFF_FFFF,
            64'h0010_0000_0000_0000, 64'h7FEF_FFFF_FFFF_FFFF,
            64'h3FF0_0000_0000_0000, 64'h4010_0000_0000_0000,
            64'h4000_0000_0000_0000, 64'h3FD0_0000_0000_0000,
            64'hBFF0_0000_0000_0000, 64'h8000_0000_0000_0001,
            64'h3FEF_FFFF_FFFF_FFFF, 64'h5555_5555_5555_5555,
            64'h2AAA_AAAA_AAAA_AAAA
        };
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_ops[i])
            send_operand(directed_ops[i]);
        drain();

        // back-pressure: cheap operands while the receiver holds off
        long_hold = 1'b1;
        for (int i = 0; i < 10; i++)
            send_operand({1'b1, 31'($urandom), 32'($urandom)});
        drain();

        for (int i = 0; i < 320; i++)
        begin
            if (i == 270)
                idle_on = 1'b0;
            send_operand(random_operand());
        end
        drain();
        repeat (50) @(posedge clk);

        $display("Sent %0d operands, checked %0d roots: specials, subnormals, extremes,",
                 items_sent, results_seen);
        $display("random patterns, idle bursts on both sides and a long output stall.");
        if (errors == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
